/* hdl/pgsrle_pkg.sv */
package pgsrle_pkg;

  // field widths fixed by the coded format and the result layout
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned DIM_W   = 16;
  localparam int unsigned COL_W   = 12;
  localparam int unsigned RUN_W   = 14;
  localparam int unsigned CFG_IDX_W = 1;

  localparam int unsigned MAX_WIDTH_DEF  = 3840;
  localparam int unsigned MAX_HEIGHT_DEF = 2160;

  // flag byte layout
  localparam int unsigned FLAG_LONG_BIT   = 6;
  localparam int unsigned FLAG_COLOUR_BIT = 7;
  localparam int unsigned RUN_LO_BITS     = 6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OBJECT_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OBJECT_HEIGHT = 1'd1;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_FLAGS  = 4'b0010,
    PH_LONG   = 4'b0100,
    PH_COLOUR = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [COL_W-1:0]  start_column;
    logic [COL_W-1:0]  line_number;
    logic [COL_W-1:0]  pixel_count;
    logic [BYTE_W-1:0] palette_index;
    logic              object_done;
    logic              dimension_error;
  } result_t;

endpackage

/* hdl/pgsrle_if.sv */
interface pgsrle_in_if;
  logic                           valid;
  logic                           ready;
  logic [pgsrle_pkg::BYTE_W-1:0]  code_byte;
  logic                           final_byte;

  modport source (output valid, code_byte, final_byte, input ready);
  modport sink (input valid, code_byte, final_byte, output ready);
endinterface

interface pgsrle_out_if;
  logic                           valid;
  logic                           ready;
  logic [pgsrle_pkg::COL_W-1:0]   start_column;
  logic [pgsrle_pkg::COL_W-1:0]   line_number;
  logic [pgsrle_pkg::COL_W-1:0]   pixel_count;
  logic [pgsrle_pkg::BYTE_W-1:0]  palette_index;
  logic                           object_done;
  logic                           dimension_error;

  modport source (output valid, start_column, line_number, pixel_count, palette_index,
                  object_done, dimension_error, input ready);
  modport sink (input valid, start_column, line_number, pixel_count, palette_index,
                object_done, dimension_error, output ready);
endinterface

/* hdl/pgsrle_token.sv */
module pgsrle_token #(
  parameter int unsigned MAX_WIDTH  = pgsrle_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = pgsrle_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              acc,
  input  logic [pgsrle_pkg::BYTE_W-1:0]     code_byte,
  input  logic                              final_byte,
  input  logic [pgsrle_pkg::DIM_W-1:0]      object_width,
  input  logic [pgsrle_pkg::DIM_W-1:0]      object_height,
  output logic                              emit,
  output pgsrle_pkg::result_t               result
);

  localparam int unsigned COL_W  = pgsrle_pkg::COL_W;
  localparam int unsigned RUN_W  = pgsrle_pkg::RUN_W;
  localparam int unsigned BYTE_W = pgsrle_pkg::BYTE_W;
  localparam int unsigned DIM_W  = pgsrle_pkg::DIM_W;
  localparam int unsigned LO     = pgsrle_pkg::RUN_LO_BITS;

  pgsrle_pkg::phase_t  phase_r, phase_nxt;
  logic [BYTE_W-1:0]   flags_r, flags_nxt;
  logic [RUN_W-1:0]    run_r, run_nxt;
  logic [COL_W-1:0]    column_r, column_nxt;
  logic [COL_W-1:0]    row_r, row_nxt;

  logic                dims_ok;
  logic [COL_W-1:0]    w12, h12;
  logic                active;
  logic                run_req;
  logic [RUN_W-1:0]    run_len;
  logic [BYTE_W-1:0]   run_colour;
  logic                col_full;
  logic [COL_W-1:0]    room;
  logic [COL_W-1:0]    cnt;
  logic                have;

  assign dims_ok = (object_width != '0) && (object_width <= DIM_W'(MAX_WIDTH)) &&
                   (object_height != '0) && (object_height <= DIM_W'(MAX_HEIGHT));
  assign w12     = object_width[COL_W-1:0];
  assign h12     = object_height[COL_W-1:0];
  assign active  = dims_ok && (row_r < h12);

  // token phase walk
  always_comb begin
    phase_nxt  = phase_r;
    flags_nxt  = flags_r;
    run_nxt    = run_r;
    run_req    = 1'b0;
    run_len    = run_r;
    run_colour = '0;
    row_nxt    = row_r;
    column_nxt = column_r;
    if (active) begin
      unique case (phase_r)
        pgsrle_pkg::PH_IDLE: begin
          if (code_byte != '0) begin
            run_req    = 1'b1;
            run_len    = RUN_W'(1);
            run_colour = code_byte;
          end else begin
            phase_nxt = pgsrle_pkg::PH_FLAGS;
          end
        end
        pgsrle_pkg::PH_FLAGS: begin
          if (code_byte == '0) begin
            // end of line
            column_nxt = '0;
            row_nxt    = row_r + COL_W'(1);
            phase_nxt  = pgsrle_pkg::PH_IDLE;
          end else begin
            flags_nxt = code_byte;
            if (code_byte[pgsrle_pkg::FLAG_LONG_BIT]) begin
              phase_nxt = pgsrle_pkg::PH_LONG;
            end else begin
              run_nxt = RUN_W'(code_byte[LO-1:0]);
              run_len = RUN_W'(code_byte[LO-1:0]);
              if (code_byte[pgsrle_pkg::FLAG_COLOUR_BIT]) begin
                phase_nxt = pgsrle_pkg::PH_COLOUR;
              end else begin
                phase_nxt = pgsrle_pkg::PH_IDLE;
                run_req   = 1'b1;
              end
            end
          end
        end
        pgsrle_pkg::PH_LONG: begin
          run_nxt = {flags_r[LO-1:0], code_byte};
          run_len = {flags_r[LO-1:0], code_byte};
          if (flags_r[pgsrle_pkg::FLAG_COLOUR_BIT]) begin
            phase_nxt = pgsrle_pkg::PH_COLOUR;
          end else begin
            phase_nxt = pgsrle_pkg::PH_IDLE;
            run_req   = 1'b1;
          end
        end
        pgsrle_pkg::PH_COLOUR: begin
          phase_nxt  = pgsrle_pkg::PH_IDLE;
          run_req    = 1'b1;
          run_colour = code_byte;
        end
        default: begin
          phase_nxt = pgsrle_pkg::PH_IDLE;
        end
      endcase
    end
    // clip against the right edge, column saturates at the width
    col_full = column_r >= w12;
    room     = w12 - column_r;
    cnt      = (run_len < {2'b00, room}) ? run_len[COL_W-1:0] : room;
    have     = active && run_req && !col_full && (cnt != '0);
    if (active && run_req) begin
      column_nxt = col_full ? w12 : column_r + cnt;
    end
    if (final_byte) begin
      phase_nxt  = pgsrle_pkg::PH_IDLE;
      flags_nxt  = '0;
      run_nxt    = '0;
      column_nxt = '0;
      row_nxt    = '0;
    end
  end

  always_comb begin
    result = '0;
    if (!dims_ok) begin
      emit                   = final_byte;
      result.object_done     = 1'b1;
      result.dimension_error = 1'b1;
    end else begin
      emit               = have || final_byte;
      result.object_done = final_byte;
      if (have) begin
        result.start_column  = column_r;
        result.line_number   = row_r;
        result.pixel_count   = cnt;
        result.palette_index = run_colour;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= pgsrle_pkg::PH_IDLE;
      flags_r  <= '0;
      run_r    <= '0;
      column_r <= '0;
      row_r    <= '0;
    end else if (acc && (dims_ok || final_byte)) begin
      phase_r  <= phase_nxt;
      flags_r  <= flags_nxt;
      run_r    <= run_nxt;
      column_r <= column_nxt;
      row_r    <= row_nxt;
    end
  end

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && final_byte |=> column_r == '0 && row_r == '0 && phase_r == pgsrle_pkg::PH_IDLE)
    else $error("state not cleared after final byte");

  a_bad_dims_hold: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !dims_ok && !final_byte |=> $stable(column_r) && $stable(row_r) && $stable(phase_r))
    else $error("state moved on a byte with invalid dimensions");

endmodule

/* hdl/pgsrle_out_stage.sv */
module pgsrle_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  pgsrle_pkg::result_t  push_data,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pgsrle_pkg::result_t  out_data
);

  logic                 main_valid_r;
  logic                 skid_valid_r;
  pgsrle_pkg::result_t  main_data_r;
  pgsrle_pkg::result_t  skid_data_r;

  // skid entry catches the result decoded while the output is stalled
  assign in_ready  = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!main_valid_r || out_ready) begin
      if (skid_valid_r) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        main_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid_r || out_ready) begin
      main_data_r <= skid_valid_r ? skid_data_r : push_data;
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid entry held with empty output register");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    push && main_valid_r && !out_ready |=> skid_valid_r && skid_data_r == $past(push_data))
    else $error("result lost while output stalled");

endmodule

/* hdl/pgs_rle_run_decoder.sv */
// Run decoder for the run-length coded bitmap of one subtitle object. One coded
// byte is taken per cycle (in_if) while in_if.ready is high; each byte that
// completes a visible run, or ends the object, leaves one registered result on
// out_if. The token phase, column and row are updated in the same cycle the
// byte is taken, so bytes stream back to back with no dependency stall; a
// two-entry output stage keeps input flowing under output stall until its skid
// entry fills and in_if.ready drops. object_width and object_height are written
// through the cfg_ port and must only change between objects; out-of-range
// values make the final byte return a done result with dimension_error set.
module pgs_rle_run_decoder #(
  parameter int unsigned MAX_WIDTH  = pgsrle_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = pgsrle_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  pgsrle_in_if.sink                           in_if,
  pgsrle_out_if.source                        out_if,
  input  logic                                cfg_we,
  input  logic [pgsrle_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pgsrle_pkg::DIM_W-1:0]        cfg_wdata
);

  logic [pgsrle_pkg::DIM_W-1:0] width_r;
  logic [pgsrle_pkg::DIM_W-1:0] height_r;
  logic                         acc;
  logic                         emit;
  logic                         in_ready;
  pgsrle_pkg::result_t          dec_result;
  pgsrle_pkg::result_t          out_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= '0;
      height_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pgsrle_pkg::REG_OBJECT_WIDTH:  width_r  <= cfg_wdata;
        pgsrle_pkg::REG_OBJECT_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_if.ready = in_ready;
  assign acc         = in_if.valid && in_ready;

  pgsrle_token #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_token (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc           (acc),
    .code_byte     (in_if.code_byte),
    .final_byte    (in_if.final_byte),
    .object_width  (width_r),
    .object_height (height_r),
    .emit          (emit),
    .result        (dec_result)
  );

  pgsrle_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (acc && emit),
    .push_data (dec_result),
    .in_ready  (in_ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_data  (out_data)
  );

  assign out_if.start_column    = out_data.start_column;
  assign out_if.line_number     = out_data.line_number;
  assign out_if.pixel_count     = out_data.pixel_count;
  assign out_if.palette_index   = out_data.palette_index;
  assign out_if.object_done     = out_data.object_done;
  assign out_if.dimension_error = out_data.dimension_error;

endmodule
